>>> sv/rcl_pkg.sv
`timescale 1ns / 1ps

package rcl_pkg;

	localparam int ALPHA = 26;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [4:0] letter_t;

	// One letter with the odometer position it is to be enciphered at
	typedef struct packed {
		letter_t letter;
		letter_t fast;
		letter_t middle;
		letter_t slow;
	} job_t;

	typedef enum logic [2:0] {
		ROT_FAST,
		ROT_MEDIUM,
		ROT_SLOW,
		ROT_REFLECT,
		ROT_INV_FAST,
		ROT_INV_MEDIUM,
		ROT_INV_SLOW
	} rotor_e;

	localparam letter_t TAB_FAST [0:25] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
		5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
	localparam letter_t TAB_MEDIUM [0:25] = '{
		5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
		5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
	localparam letter_t TAB_SLOW [0:25] = '{
		5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
		5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
	localparam letter_t TAB_REFLECT [0:25] = '{
		5'd8, 5'd23, 5'd20, 5'd7, 5'd5, 5'd4, 5'd25, 5'd3, 5'd0, 5'd14, 5'd12, 5'd19, 5'd10,
		5'd16, 5'd9, 5'd22, 5'd13, 5'd18, 5'd17, 5'd11, 5'd2, 5'd24, 5'd15, 5'd1, 5'd21, 5'd6};
	localparam letter_t TAB_INV_FAST [0:25] = '{
		5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
		5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
	localparam letter_t TAB_INV_MEDIUM [0:25] = '{
		5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
		5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
	localparam letter_t TAB_INV_SLOW [0:25] = '{
		5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
		5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};

	localparam letter_t LAST_LETTER = letter_t'(ALPHA - 1);

	// Bring 0..31 into 0..25
	function automatic letter_t mod_reduce(input letter_t x);
		letter_t r;
		r = (x >= letter_t'(ALPHA)) ? letter_t'(x - letter_t'(ALPHA)) : x;
		return r;
	endfunction

	function automatic letter_t add_mod(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(ALPHA)) begin
			s = s - 6'(ALPHA);
		end
		return s[4:0];
	endfunction

	function automatic letter_t sub_mod(input letter_t a, input letter_t b);
		letter_t r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = letter_t'(6'(a) + 6'(ALPHA) - 6'(b));
		end
		return r;
	endfunction

	// Operands are always below 26
	function automatic letter_t lookup(input rotor_e r, input letter_t i);
		letter_t y;
		case (r)
			ROT_FAST:       y = TAB_FAST[i];
			ROT_MEDIUM:     y = TAB_MEDIUM[i];
			ROT_SLOW:       y = TAB_SLOW[i];
			ROT_REFLECT:    y = TAB_REFLECT[i];
			ROT_INV_FAST:   y = TAB_INV_FAST[i];
			ROT_INV_MEDIUM: y = TAB_INV_MEDIUM[i];
			ROT_INV_SLOW:   y = TAB_INV_SLOW[i];
			default:        y = '0;
		endcase
		return y;
	endfunction

	// Offset by the digit, substitute, take the offset back out
	function automatic letter_t through_rotor(input rotor_e r, input letter_t x,
			input letter_t d);
		letter_t y;
		y = lookup(r, add_mod(x, d));
		return sub_mod(y, d);
	endfunction

endpackage

>>> sv/rcl_front.sv
`timescale 1ns / 1ps

module rcl_front import rcl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  letter_t letter_in,
	input  logic    restart,
	input  logic    q_full,
	output logic    push,
	output job_t    push_job
);

	letter_t fast_q, medium_q, slow_q;
	letter_t fast_nxt, medium_nxt, slow_nxt;

	// Odometer step, or load position 1 on restart
	always_comb begin
		fast_nxt   = fast_q;
		medium_nxt = medium_q;
		slow_nxt   = slow_q;
		if (restart) begin
			fast_nxt   = letter_t'(1);
			medium_nxt = '0;
			slow_nxt   = '0;
		end else if (fast_q != LAST_LETTER) begin
			fast_nxt = fast_q + letter_t'(1);
		end else begin
			fast_nxt = '0;
			if (medium_q != LAST_LETTER) begin
				medium_nxt = medium_q + letter_t'(1);
			end else begin
				medium_nxt = '0;
				slow_nxt   = (slow_q != LAST_LETTER) ? slow_q + letter_t'(1) : '0;
			end
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_job.letter = mod_reduce(letter_in);
		push_job.fast   = fast_nxt;
		push_job.middle = medium_nxt;
		push_job.slow   = slow_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q   <= '0;
			medium_q <= '0;
			slow_q   <= '0;
		end else if (push) begin
			fast_q   <= fast_nxt;
			medium_q <= medium_nxt;
			slow_q   <= slow_nxt;
		end
	end

endmodule

>>> sv/rcl_queue.sv
`timescale 1ns / 1ps

module rcl_queue import rcl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count lost a push");

endmodule

>>> sv/rcl_back.sv
`timescale 1ns / 1ps

module rcl_back import rcl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  job_t    head_job,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_stall,
	output letter_t letter_out
);

	logic    valid_s1, valid_s2;
	letter_t x_s1;
	letter_t fast_s1, medium_s1, slow_s1;
	letter_t fwd, inv;
	letter_t x_s2;
	logic    en_s1, en_s2;

	assign en_s2 = !valid_s2 || !out_stall;
	assign en_s1 = !valid_s1 || en_s2;
	assign pop   = head_valid && en_s1;

	// Forward rotors and reflector
	always_comb begin
		fwd = through_rotor(ROT_FAST, head_job.letter, head_job.fast);
		fwd = through_rotor(ROT_MEDIUM, fwd, head_job.middle);
		fwd = through_rotor(ROT_SLOW, fwd, head_job.slow);
		fwd = lookup(ROT_REFLECT, fwd);
	end

	// Return path through the inverse rotors
	always_comb begin
		inv = through_rotor(ROT_INV_SLOW, x_s1, slow_s1);
		inv = through_rotor(ROT_INV_MEDIUM, inv, medium_s1);
		inv = through_rotor(ROT_INV_FAST, inv, fast_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= head_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && head_valid) begin
			x_s1      <= fwd;
			fast_s1   <= head_job.fast;
			medium_s1 <= head_job.middle;
			slow_s1   <= head_job.slow;
		end
		if (en_s2 && valid_s1) begin
			x_s2 <= inv;
		end
	end

	assign out_valid  = valid_s2;
	assign letter_out = x_s2;

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> valid_s1)
		else $error("stage 1 item dropped under stall");

	a_no_pop_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> !pop)
		else $error("pop while pipeline blocked");

	a_output_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (letter_out <= LAST_LETTER))
		else $error("result letter out of range");

endmodule

>>> sv/rotor_cipher_letter_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  -----------------------------
// in       in_valid / in_stall    letter_in[4:0], restart
// out      out_valid / out_stall  letter_out[4:0]
//
// One letter per cycle while out_stall is low; each result passes the queue slot,
// the forward rotors plus reflector register and the inverse rotors register in turn.
// The two-entry queue between odometer and rotor pipeline sets the stall depth.
// Reset clears the odometer to position 0, empties the queue and the pipeline.
// in_stall follows the queue-full flag alone: with both stages loaded and a result held
// by out_stall, the queue stops draining and in_stall rises once it holds two entries.

module rotor_cipher_letter_unit import rcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] letter_in,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] letter_out
);

	logic push, pop, q_full, head_valid;
	job_t push_job, head_job;

	// Front: step the odometer and tag each letter with its position
	rcl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.letter_in (letter_in),
		.restart   (restart),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	// Decouple: hold tagged letters while the back end is stalled
	rcl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: two-stage rotor pipeline ending in the output register
	rcl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out)
	);

endmodule

>>> bench/rcl_cipher_checker.sv
`timescale 1ns / 1ps

module rcl_cipher_checker import rcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [4:0] letter_in,
	input  logic       restart,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [4:0] letter_out,
	output int         fail_count,
	output int         pending
);

	localparam int REPORT_MAX = 10;

	// Rotor wirings, one ASCII letter per byte, leftmost byte is entry A
	localparam bit [8*26-1:0] WIRE_FAST       = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
	localparam bit [8*26-1:0] WIRE_MEDIUM     = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
	localparam bit [8*26-1:0] WIRE_SLOW       = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
	localparam bit [8*26-1:0] WIRE_REFLECT    = "IXUHFEZDAOMTKQJWNSRLCYPBVG";
	localparam bit [8*26-1:0] WIRE_INV_FAST   = "TAGBPCSDQEUFVNZHYIXJWLRKOM";
	localparam bit [8*26-1:0] WIRE_INV_MEDIUM = "AJPCZWRLFBDKOTYUQGENHXMIVS";
	localparam bit [8*26-1:0] WIRE_INV_SLOW   = "UWYGADFPVZBECKMTHXSLRINQOJ";

	letter_t odo_fast = '0;
	letter_t odo_medium = '0;
	letter_t odo_slow = '0;
	letter_t cipher_due [$];
	int      mismatches = 0;

	assign fail_count = mismatches;
	assign pending = cipher_due.size();

	function automatic int wired(input bit [8*26-1:0] w, input int i);
		return int'(w[8*(25-i) +: 8]) - 65;
	endfunction

	function automatic int rotor_pass(input bit [8*26-1:0] w, input int x, input int d);
		int y;
		y = wired(w, (x + d) % 26);
		return (y + 26 - d) % 26;
	endfunction

	// Step the odometer, or load position 1, then run the letter through the rotors
	function automatic letter_t encipher_letter(input letter_t raw, input logic fresh);
		int x;
		int f;
		int m;
		int s;
		if (fresh) begin
			odo_fast = letter_t'(1);
			odo_medium = '0;
			odo_slow = '0;
		end else if (odo_fast != LAST_LETTER) begin
			odo_fast = odo_fast + letter_t'(1);
		end else begin
			odo_fast = '0;
			if (odo_medium != LAST_LETTER) begin
				odo_medium = odo_medium + letter_t'(1);
			end else begin
				odo_medium = '0;
				odo_slow = (odo_slow == LAST_LETTER) ? letter_t'(0) :
					letter_t'(odo_slow + letter_t'(1));
			end
		end
		f = int'(odo_fast);
		m = int'(odo_medium);
		s = int'(odo_slow);
		x = int'(raw) % 26;
		x = rotor_pass(WIRE_FAST, x, f);
		x = rotor_pass(WIRE_MEDIUM, x, m);
		x = rotor_pass(WIRE_SLOW, x, s);
		x = wired(WIRE_REFLECT, x);
		x = rotor_pass(WIRE_INV_SLOW, x, s);
		x = rotor_pass(WIRE_INV_MEDIUM, x, m);
		x = rotor_pass(WIRE_INV_FAST, x, f);
		return letter_t'(x);
	endfunction

	// Compare outputs first: a result never belongs to the letter taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cipher_due.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected letter_out %0d with nothing pending", letter_out);
					mismatches++;
				end else begin
					letter_t want;
					want = cipher_due.pop_front();
					if (letter_out !== want) begin
						if (mismatches < REPORT_MAX)
							$display("letter_out mismatch: expected %0d got %0d", want, letter_out);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				cipher_due.push_back(encipher_letter(letter_in, restart));
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import rcl_pkg::*;

	localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer before giving up
	localparam int DRAIN_CYCLES = 20;    // leave room for stray results after nothing is pending
	localparam int RANDOM_ITEMS = 1040;
	localparam int SWEEP_ITEMS  = 26 * 26 + 8;  // one medium-digit turn plus a few

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [4:0] letter_in = '0;
	logic       restart = 1'b0;
	logic       out_stall = 1'b0;
	wire        in_stall;
	wire        out_valid;
	wire  [4:0] letter_out;
	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	int         sent = 0;
	bit         send_calm = 1'b0;

	rotor_cipher_letter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.letter_in  (letter_in),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out)
	);

	rcl_cipher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.letter_in  (letter_in),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run once no transfer has happened for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offer one letter after a random gap and hold it until the transfer.
	// Valid stays high across back-to-back letters; it only drops inside a gap.
	task automatic send_letter(input logic [4:0] l, input logic fresh);
		int gap;
		if (sent % 48 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
		gap = send_calm ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		letter_in <= l;
		restart <= fresh;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Mostly in-range letters, now and then one of the six aliases above Z
	function automatic logic [4:0] pick_letter();
		if ($urandom_range(0, 15) == 0)
			return 5'($urandom_range(26, 31));
		return 5'($urandom_range(0, 25));
	endfunction

	// Receiver: hold stall for a random count per result, then take one
	initial begin : receiver
		int hold;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			hold = calm ? 0 : $urandom_range(0, 10);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin : stimulus
		int msg_len;
		int done_random;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// First letter after reset steps the odometer from zero to position 1
		send_letter(5'd0, 1'b0);
		send_letter(5'd25, 1'b0);
		// Aliases above Z fold back onto A..F
		for (int i = 26; i < 32; i++)
			send_letter(5'(i), 1'b0);
		// Restart gives the same position as the first letter after reset
		send_letter(5'd0, 1'b1);
		send_letter(5'd25, 1'b1);
		send_letter(5'd31, 1'b1);
		send_letter(5'd13, 1'b1);
		for (int i = 0; i < 6; i++)
			send_letter(5'(i * 5), 1'b0);
		send_letter(5'd1, 1'b1);
		send_letter(5'd30, 1'b0);

		// Run past one medium-digit turn from position 1 so fast and medium wrap
		// and the slow digit steps
		send_letter(pick_letter(), 1'b1);
		for (int i = 0; i < SWEEP_ITEMS; i++)
			send_letter(pick_letter(), 1'b0);

		// Messages of random length, most opened by a restart, a few broken
		done_random = 0;
		while (done_random < RANDOM_ITEMS) begin
			msg_len = $urandom_range(1, 60);
			send_letter(pick_letter(), $urandom_range(0, 7) != 0);
			for (int i = 1; i < msg_len; i++)
				send_letter(pick_letter(), $urandom_range(0, 49) == 0);
			done_random += msg_len;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
sv/rcl_pkg.sv
sv/rcl_front.sv
sv/rcl_queue.sv
sv/rcl_back.sv
sv/rotor_cipher_letter_unit.sv
bench/rcl_cipher_checker.sv
bench/tb.sv
